// File: sv/ps2mct_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker package
// Shared widths, register indexes and the types passed between the blocks.
// ----------------------------------------------------------------------------
package ps2mct_pkg;

    // Width of the internal cursor position registers.
    localparam int COORD_BITS = 10;
    // Width of the cursor fields on the result channel.
    localparam int CURSOR_W   = 10;
    // Width of the limit registers.
    localparam int LIMIT_W    = 10;
    // Width of the gain register.
    localparam int GAIN_W     = 4;
    // Width of the configuration index and data.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 10;

    // Signed width used for position arithmetic; holds position plus a scaled delta.
    localparam int SUM_W      = COORD_BITS + 8;
    // Signed product of a nine-bit delta and the gain.
    localparam int PROD_W     = 9 + GAIN_W + 1;

    // Reset values.
    localparam logic [LIMIT_W-1:0]    X_LIMIT_RST = LIMIT_W'(798);
    localparam logic [LIMIT_W-1:0]    Y_LIMIT_RST = LIMIT_W'(596);
    localparam logic [GAIN_W-1:0]     GAIN_RST    = GAIN_W'(1);
    localparam logic [COORD_BITS-1:0] POS_RST     = COORD_BITS'(100);

    // Largest position the coordinate registers can hold.
    localparam logic [COORD_BITS-1:0] COORD_MAX   = '1;

    // Header bit positions.
    localparam int HDR_LEFT   = 0;
    localparam int HDR_RIGHT  = 1;
    localparam int HDR_SYNC   = 3;
    localparam int HDR_X_SIGN = 4;
    localparam int HDR_Y_SIGN = 5;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_X_LIMIT = 2'd0,
        REG_Y_LIMIT = 2'd1,
        REG_GAIN    = 2'd2
    } reg_idx_t;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [LIMIT_W-1:0] x_limit;
        logic [LIMIT_W-1:0] y_limit;
        logic [GAIN_W-1:0]  gain;
    } cfg_t;

    // A completed packet from the framer.
    typedef struct packed {
        logic       complete;
        logic [7:0] header;
        logic [7:0] dx;
        logic [7:0] dy;
    } pkt_t;

    // One result beat.
    typedef struct packed {
        logic [CURSOR_W-1:0] cursor_x;
        logic [CURSOR_W-1:0] cursor_y;
        logic                left_release;
        logic                right_release;
    } result_t;

endpackage

// File: sv/ps2mct_if.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker channel interfaces
// Valid/ready channels for mouse bytes, cursor results and register writes.
// ----------------------------------------------------------------------------

// Mouse byte channel.
interface ps2mct_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Cursor result channel.
interface ps2mct_cursor_if import ps2mct_pkg::*;;
    logic                valid;
    logic                ready;
    logic [CURSOR_W-1:0] cursor_x;
    logic [CURSOR_W-1:0] cursor_y;
    logic                left_release;
    logic                right_release;

    modport source (output valid, output cursor_x, output cursor_y,
                    output left_release, output right_release, input ready);
    modport sink   (input valid, input cursor_x, input cursor_y,
                    input left_release, input right_release, output ready);
endinterface

// Configuration write channel.
interface ps2mct_cfg_if import ps2mct_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

// File: sv/ps2mct_cfg_regs.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker configuration registers
// Holds the two clamp limits and the movement gain.
// ----------------------------------------------------------------------------
module ps2mct_cfg_regs import ps2mct_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    ps2mct_cfg_if.sink         cfg,
    output cfg_t               cfg_out
);

    logic [LIMIT_W-1:0] x_limit_reg;
    logic [LIMIT_W-1:0] y_limit_reg;
    logic [GAIN_W-1:0]  gain_reg;

    // Writes are always taken; an unknown index is ignored.
    assign cfg.ready = 1'b1;

    // Register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_limit_reg <= X_LIMIT_RST;
            y_limit_reg <= Y_LIMIT_RST;
            gain_reg    <= GAIN_RST;
        end
        else if (cfg.valid)
        begin
            unique case (reg_idx_t'(cfg.addr))
                REG_X_LIMIT: x_limit_reg <= cfg.data[LIMIT_W-1:0];
                REG_Y_LIMIT: y_limit_reg <= cfg.data[LIMIT_W-1:0];
                REG_GAIN:    gain_reg    <= cfg.data[GAIN_W-1:0];
                default:     ;
            endcase
        end
    end

    assign cfg_out.x_limit = x_limit_reg;
    assign cfg_out.y_limit = y_limit_reg;
    assign cfg_out.gain    = gain_reg;

endmodule

// File: sv/ps2mct_framer.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker packet framer
// Aligns mouse bytes into header, X and Y bytes and flags a complete packet.
// ----------------------------------------------------------------------------
module ps2mct_framer import ps2mct_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic [7:0] byte_data,
    input  logic       advance,
    output pkt_t       pkt
);

    typedef enum logic [1:0] {
        IDX_HEADER = 2'd0,
        IDX_DX     = 2'd1,
        IDX_DY     = 2'd2
    } byte_idx_t;

    byte_idx_t  byte_idx_reg;
    byte_idx_t  byte_idx_next;
    logic [7:0] header_reg;
    logic [7:0] dx_reg;
    logic       complete;

    // Next byte position; a header byte without its sync bit is dropped.
    always_comb
    begin
        byte_idx_next = byte_idx_reg;
        complete      = 1'b0;
        unique case (byte_idx_reg)
            IDX_HEADER:
            begin
                if (byte_data[HDR_SYNC])
                begin
                    byte_idx_next = IDX_DX;
                end
            end
            IDX_DX:
            begin
                byte_idx_next = IDX_DY;
            end
            default:
            begin
                byte_idx_next = IDX_HEADER;
                complete      = 1'b1;
            end
        endcase
    end

    // Position counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_idx_reg <= IDX_HEADER;
        end
        else if (byte_valid && advance)
        begin
            byte_idx_reg <= byte_idx_next;
        end
    end

    // Header and X delta capture.
    always_ff @(posedge clk)
    begin
        if (byte_valid && advance)
        begin
            if (byte_idx_reg == IDX_HEADER)
            begin
                header_reg <= byte_data;
            end
            if (byte_idx_reg == IDX_DX)
            begin
                dx_reg <= byte_data;
            end
        end
    end

    assign pkt.complete = byte_valid && complete;
    assign pkt.header   = header_reg;
    assign pkt.dx       = dx_reg;
    assign pkt.dy       = byte_data;

endmodule

// File: sv/ps2mct_cursor.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker cursor update
// Scales the packet deltas, moves and clamps the cursor, detects releases.
// ----------------------------------------------------------------------------
module ps2mct_cursor import ps2mct_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  pkt_t    pkt,
    input  logic    commit,
    output result_t result
);

    logic [COORD_BITS-1:0] pos_x_reg;
    logic [COORD_BITS-1:0] pos_y_reg;
    logic                  left_held_reg;
    logic                  right_held_reg;

    logic signed [8:0]        dx9;
    logic signed [8:0]        dy9;
    logic signed [GAIN_W:0]   gain_s;
    logic signed [PROD_W-1:0] dx_scaled;
    logic signed [PROD_W-1:0] dy_scaled;
    logic signed [SUM_W-1:0]  sum_x;
    logic signed [SUM_W-1:0]  sum_y;
    logic [COORD_BITS-1:0]    pos_x_next;
    logic [COORD_BITS-1:0]    pos_y_next;
    logic                     left_release;
    logic                     right_release;

    // Clamp a signed value to 0..min(limit, largest coordinate).
    function automatic logic [COORD_BITS-1:0] clamp_coord(
        input logic signed [SUM_W-1:0] v,
        input logic [LIMIT_W-1:0]      lim
    );
        logic signed [SUM_W-1:0] top;
        logic signed [SUM_W-1:0] cmax;
        logic signed [SUM_W-1:0] res;
        cmax = SUM_W'(COORD_MAX);
        top  = SUM_W'(lim);
        if (top > cmax)
        begin
            top = cmax;
        end
        res = v;
        if (res > top)
        begin
            res = top;
        end
        if (res < 0)
        begin
            res = '0;
        end
        return res[COORD_BITS-1:0];
    endfunction

    // Nine-bit deltas with the sign bits taken from the header.
    assign dx9    = {pkt.header[HDR_X_SIGN], pkt.dx};
    assign dy9    = {pkt.header[HDR_Y_SIGN], pkt.dy};
    assign gain_s = {1'b0, cfg.gain};

    // Scale, move and clamp; screen y grows downwards.
    always_comb
    begin
        dx_scaled  = PROD_W'(dx9) * PROD_W'(gain_s);
        dy_scaled  = PROD_W'(dy9) * PROD_W'(gain_s);
        sum_x      = signed'(SUM_W'(pos_x_reg)) + SUM_W'(dx_scaled);
        sum_y      = signed'(SUM_W'(pos_y_reg)) - SUM_W'(dy_scaled);
        pos_x_next = clamp_coord(sum_x, cfg.x_limit);
        pos_y_next = clamp_coord(sum_y, cfg.y_limit);
    end

    // A release event is a held button that is now seen released.
    assign left_release  = left_held_reg  && !pkt.header[HDR_LEFT];
    assign right_release = right_held_reg && !pkt.header[HDR_RIGHT];

    // Cursor and button state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg      <= POS_RST;
            pos_y_reg      <= POS_RST;
            left_held_reg  <= 1'b0;
            right_held_reg <= 1'b0;
        end
        else if (commit)
        begin
            pos_x_reg      <= pos_x_next;
            pos_y_reg      <= pos_y_next;
            left_held_reg  <= pkt.header[HDR_LEFT];
            right_held_reg <= pkt.header[HDR_RIGHT];
        end
    end

    assign result.cursor_x      = CURSOR_W'(pos_x_next);
    assign result.cursor_y      = CURSOR_W'(pos_y_next);
    assign result.left_release  = left_release;
    assign result.right_release = right_release;

endmodule

// File: sv/ps2_mouse_cursor_tracker.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker
// Builds three-byte PS/2 mouse packets and tracks a clamped cursor position.
// ----------------------------------------------------------------------------
// One mouse byte is accepted per clock cycle while the input is not stalled.
// Each byte is first held in an input register; the framer and the cursor
// update consume it from there, and the third byte of a packet loads the
// output register, from which its result beat is offered. The output register
// lets new bytes flow while a result waits; only a result held by the sink
// together with a further completed packet stalls the input. Header bytes
// without bit 3 set are dropped. Configuration writes are taken in every cycle
// and should only be issued while the block is idle.
module ps2_mouse_cursor_tracker import ps2mct_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    ps2mct_byte_if.sink      mouse,
    ps2mct_cursor_if.source  cursor,
    ps2mct_cfg_if.sink       cfg
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;

    cfg_t    cfg_cur;
    pkt_t    pkt;
    result_t result;
    logic    advance;

    // Configuration registers.
    ps2mct_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_cur)
    );

    // The held byte moves on unless it completes a packet while a result waits.
    assign advance = in_valid_reg &&
                     (!pkt.complete || !out_valid_reg || cursor.ready);

    assign mouse.ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (mouse.ready)
        begin
            in_valid_reg <= mouse.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mouse.valid && mouse.ready)
        begin
            in_byte_reg <= mouse.rx_byte;
        end
    end

    // Packet framing.
    ps2mct_framer u_framer (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (in_valid_reg),
        .byte_data  (in_byte_reg),
        .advance    (advance),
        .pkt        (pkt)
    );

    // Cursor update.
    ps2mct_cursor u_cursor (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_cur),
        .pkt    (pkt),
        .commit (advance && pkt.complete),
        .result (result)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && pkt.complete)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (cursor.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && pkt.complete)
        begin
            out_reg <= result;
        end
    end

    assign cursor.valid         = out_valid_reg;
    assign cursor.cursor_x      = out_reg.cursor_x;
    assign cursor.cursor_y      = out_reg.cursor_y;
    assign cursor.left_release  = out_reg.left_release;
    assign cursor.right_release = out_reg.right_release;

endmodule

// File: tb/ps2_mouse_cursor_tracker_tb.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker testbench
// Sends mouse bytes through the tracker and checks every cursor beat against
// a cycle-free model of packet framing, scaled movement, clamping and click
// detection. Directed framing and register corner cases come first. Random
// packet traffic follows, under several register settings, with noise bytes,
// broken packets, bursty sending and a stalling cursor sink.
// ----------------------------------------------------------------------------
module ps2_mouse_cursor_tracker_tb import ps2mct_pkg::*;;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int MAX_REPORTS    = 20;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_BYTES    = 250;

    // Index that no register answers to; writes to it must be ignored.
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

    logic clk;
    logic rst_n;

    ps2mct_byte_if   mouse_ch ();
    ps2mct_cursor_if cursor_ch ();
    ps2mct_cfg_if    cfg_ch ();

    ps2_mouse_cursor_tracker dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .mouse  (mouse_ch),
        .cursor (cursor_ch),
        .cfg    (cfg_ch)
    );

    // Tracker model state, starting from the reset values.
    logic [1:0]         trk_phase  = 2'd0;
    logic [7:0]         trk_header = 8'h00;
    logic [7:0]         trk_dx     = 8'h00;
    int                 trk_x      = int'(POS_RST);
    int                 trk_y      = int'(POS_RST);
    logic               trk_left   = 1'b0;
    logic               trk_right  = 1'b0;
    logic [LIMIT_W-1:0] lim_x      = X_LIMIT_RST;
    logic [LIMIT_W-1:0] lim_y      = Y_LIMIT_RST;
    logic [GAIN_W-1:0]  gain_r     = GAIN_RST;

    // Cursor beats still owed by the block, oldest first.
    result_t pending_cursors[$];

    // Run statistics and error count.
    int errors        = 0;
    int bytes_taken   = 0;
    int beats_checked = 0;
    int clicks_seen   = 0;
    int reg_writes    = 0;
    int quiet_cycles  = 0;

    // Sender burst control.
    int   burst_left   = 0;
    int   gap_max      = 10;
    logic byte_driving = 1'b0;

    // Receiver stall pattern state.
    int cycle_count = 0;
    int stall_run   = 0;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what, input int got, input int want);
        if (errors < MAX_REPORTS)
            $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
        errors++;
    endtask

    function automatic int clamp_to_limit(input int v, input logic [LIMIT_W-1:0] lim);
        int top;
        top = (int'(lim) > int'(COORD_MAX)) ? int'(COORD_MAX) : int'(lim);
        if (v > top)
            v = top;
        if (v < 0)
            v = 0;
        return v;
    endfunction

    // Advance the tracker model by one accepted mouse byte.
    function automatic void track_mouse_byte(input logic [7:0] b);
        int      dx;
        int      dy;
        result_t beat;
        if (trk_phase == 2'd0)
        begin
            if (b[HDR_SYNC])
            begin
                trk_header = b;
                trk_phase  = 2'd1;
            end
        end
        else if (trk_phase == 2'd1)
        begin
            trk_dx    = b;
            trk_phase = 2'd2;
        end
        else
        begin
            trk_phase = 2'd0;
            dx = $signed({trk_header[HDR_X_SIGN], trk_dx}) * int'(gain_r);
            dy = $signed({trk_header[HDR_Y_SIGN], b}) * int'(gain_r);
            trk_x = clamp_to_limit(trk_x + dx, lim_x);
            trk_y = clamp_to_limit(trk_y - dy, lim_y);
            beat.left_release  = 1'b0;
            beat.right_release = 1'b0;
            if (trk_header[HDR_LEFT])
                trk_left = 1'b1;
            else if (trk_left)
            begin
                beat.left_release = 1'b1;
                trk_left = 1'b0;
            end
            if (trk_header[HDR_RIGHT])
                trk_right = 1'b1;
            else if (trk_right)
            begin
                beat.right_release = 1'b1;
                trk_right = 1'b0;
            end
            beat.cursor_x = CURSOR_W'(trk_x);
            beat.cursor_y = CURSOR_W'(trk_y);
            pending_cursors.push_back(beat);
        end
    endfunction

    // Compare one accepted cursor beat with the oldest owed one.
    task automatic check_cursor_beat();
        result_t want;
        if (pending_cursors.size() == 0)
            report_mismatch("cursor beat with none owed, cursor_x",
                            int'(cursor_ch.cursor_x), 0);
        else
        begin
            want = pending_cursors.pop_front();
            if (cursor_ch.cursor_x !== want.cursor_x)
                report_mismatch("cursor_x", int'(cursor_ch.cursor_x), int'(want.cursor_x));
            if (cursor_ch.cursor_y !== want.cursor_y)
                report_mismatch("cursor_y", int'(cursor_ch.cursor_y), int'(want.cursor_y));
            if (cursor_ch.left_release !== want.left_release)
                report_mismatch("left_release", int'(cursor_ch.left_release),
                                int'(want.left_release));
            if (cursor_ch.right_release !== want.right_release)
                report_mismatch("right_release", int'(cursor_ch.right_release),
                                int'(want.right_release));
            if (want.left_release || want.right_release)
                clicks_seen++;
        end
        beats_checked++;
    endtask

    // Watch all three channels: register writes and bytes update the model,
    // cursor beats are checked, and idle cycles feed the watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            quiet_cycles++;
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.addr)
                    REG_X_LIMIT: lim_x = cfg_ch.data[LIMIT_W-1:0];
                    REG_Y_LIMIT: lim_y = cfg_ch.data[LIMIT_W-1:0];
                    REG_GAIN:    gain_r = cfg_ch.data[GAIN_W-1:0];
                    default:     ;
                endcase
                reg_writes++;
                quiet_cycles = 0;
            end
            if (mouse_ch.valid && mouse_ch.ready)
            begin
                track_mouse_byte(mouse_ch.rx_byte);
                bytes_taken++;
                quiet_cycles = 0;
            end
            if (cursor_ch.valid && cursor_ch.ready)
            begin
                check_cursor_beat();
                quiet_cycles = 0;
            end
        end
    end

    // Cursor sink: the stall pattern steps in turn through always
    // ready, coin flips, one cycle in four, and random runs of stalls.
    always @(posedge clk)
    begin
        cycle_count++;
        case ((cycle_count >> 7) & 3)
            0: cursor_ch.ready <= 1'b1;
            1: cursor_ch.ready <= 1'($urandom_range(0, 1));
            2: cursor_ch.ready <= ((cycle_count & 3) == 0);
            default:
            begin
                if (stall_run > 0)
                begin
                    stall_run--;
                    cursor_ch.ready <= 1'b0;
                end
                else
                begin
                    cursor_ch.ready <= 1'b1;
                    if ($urandom_range(0, 5) == 0)
                        stall_run = $urandom_range(1, 12);
                end
            end
        endcase
    end

    // Watchdog: ends the run when nothing has moved for too long.
    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("ps2_mouse_cursor_tracker_tb: FAIL");
        $finish;
    end

    // Send one mouse byte, opening a random gap at the start of each burst.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, gap_max);
            if (gap > 0)
            begin
                if (byte_driving)
                    mouse_ch.valid <= 1'b0;
                byte_driving = 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        mouse_ch.valid   <= 1'b1;
        mouse_ch.rx_byte <= b;
        byte_driving = 1'b1;
        @(posedge clk);
        while (!(mouse_ch.valid && mouse_ch.ready))
            @(posedge clk);
    endtask

    // Stop sending and wait until every owed beat has arrived and the
    // pipeline has had time to swallow any trailing bytes.
    task automatic settle_idle();
        if (byte_driving)
            mouse_ch.valid <= 1'b0;
        byte_driving = 1'b0;
        burst_left   = 0;
        @(posedge clk);
        while (pending_cursors.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write beat; valid stays high for a following write.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready))
            @(posedge clk);
    endtask

    // Write all three registers back to back, optionally preceded by a write
    // to the unused index.
    task automatic program_regs(input logic [CFG_DATA_W-1:0] x_lim,
                                input logic [CFG_DATA_W-1:0] y_lim,
                                input logic [CFG_DATA_W-1:0] gain_val,
                                input logic poke_unused);
        if (poke_unused)
            write_reg(REG_UNUSED, 10'h3FF);
        write_reg(REG_X_LIMIT, x_lim);
        write_reg(REG_Y_LIMIT, y_lim);
        write_reg(REG_GAIN, gain_val);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_packet(input logic [7:0] hdr, input logic [7:0] dx,
                               input logic [7:0] dy);
        send_byte(hdr);
        send_byte(dx);
        send_byte(dy);
    endtask

    // Framing under reset settings: a dropped unsynchronised byte, the largest
    // deltas both ways, ignored overflow bits, presses and both releases.
    task automatic test_framing_and_buttons();
        send_byte(8'hF7);
        send_packet(8'h08, 8'h7F, 8'h80);
        send_packet(8'hFB, 8'h00, 8'h00);
        send_packet(8'h08, 8'hFF, 8'hFF);
        settle_idle();
    endtask

    // Register corners: zero limits with full gain, full limits with full
    // gain, then zero gain with lowered limits to pull the cursor back.
    task automatic test_register_corners();
        program_regs(10'd0, 10'd0, 10'h3FF, 1'b1);
        send_packet(8'h08, 8'h10, 8'h10);
        settle_idle();
        program_regs(10'd1023, 10'd1023, 10'd15, 1'b0);
        send_packet(8'h08, 8'h7F, 8'h00);
        send_packet(8'h28, 8'h00, 8'h00);
        settle_idle();
        program_regs(10'd500, 10'd300, 10'd0, 1'b0);
        send_packet(8'h3B, 8'hAA, 8'h55);
        settle_idle();
    endtask

    // A nine-bit delta: sign in bit 8. Mostly small moves, some full range
    // and some extremes.
    function automatic logic [8:0] pick_delta();
        int mag;
        case ($urandom_range(0, 3))
            0: return 9'($urandom);
            3: return {1'($urandom_range(0, 1)), ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00};
            default:
            begin
                mag = $urandom_range(0, 20);
                return ($urandom_range(0, 1) != 0) ? 9'(512 - mag) : 9'(mag);
            end
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_limit();
        case ($urandom_range(0, 5))
            0:       return 10'd0;
            1:       return 10'd1023;
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 4))
            0:       return 10'd0;
            1:       return 10'd15;
            2:       return 10'd1;
            default: return 10'($urandom);
        endcase
    endfunction

    // Random packet traffic over several register settings. Most packets are
    // well formed; some are preceded by noise bytes or cut short.
    task automatic test_random_traffic();
        int          phase;
        int          sent;
        int          n;
        logic [8:0]  ddx;
        logic [8:0]  ddy;
        logic [7:0]  hdr;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
                program_regs(10'(X_LIMIT_RST), 10'(Y_LIMIT_RST), 10'(GAIN_RST), 1'b0);
            else
                program_regs(pick_limit(), pick_limit(), pick_gain(), 1'b0);
            gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 10);
            sent = 0;
            while (sent < PHASE_BYTES)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    n = $urandom_range(1, 3);
                    repeat (n) send_byte(8'($urandom));
                    sent += n;
                end
                ddx = pick_delta();
                ddy = pick_delta();
                hdr = 8'($urandom);
                hdr[HDR_SYNC]   = 1'b1;
                hdr[HDR_X_SIGN] = ddx[8];
                hdr[HDR_Y_SIGN] = ddy[8];
                send_byte(hdr);
                send_byte(ddx[7:0]);
                sent += 2;
                if ($urandom_range(0, 19) != 0)
                begin
                    send_byte(ddy[7:0]);
                    sent++;
                end
            end
            settle_idle();
        end
    endtask

    // Reset, then the tests in turn, then the verdict.
    initial
    begin
        rst_n            <= 1'b0;
        mouse_ch.valid   <= 1'b0;
        mouse_ch.rx_byte <= 8'h00;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.addr      <= REG_X_LIMIT;
        cfg_ch.data      <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_framing_and_buttons();
        test_register_corners();
        test_random_traffic();

        if (pending_cursors.size() != 0)
            report_mismatch("cursor beats never delivered", 0, pending_cursors.size());
        $display("covered %0d mouse bytes, %0d cursor beats checked, %0d with clicks",
                 bytes_taken, beats_checked, clicks_seen);
        $display("covered %0d register writes over %0d random settings, %0d mismatches",
                 reg_writes, RANDOM_PHASES, errors);
        if (errors == 0)
            $display("ps2_mouse_cursor_tracker_tb: PASS");
        else
            $display("ps2_mouse_cursor_tracker_tb: FAIL");
        $finish;
    end

endmodule

// File: sim.f
sv/ps2mct_pkg.sv
sv/ps2mct_if.sv
sv/ps2mct_cfg_regs.sv
sv/ps2mct_framer.sv
sv/ps2mct_cursor.sv
sv/ps2_mouse_cursor_tracker.sv
tb/ps2_mouse_cursor_tracker_tb.sv
